### src/bmhq_pkg.sv
package bmhq_pkg;

    localparam int HEAP_DEPTH_DEF = 16;
    localparam int KEY_W          = 32;
    localparam int STATUS_W       = 2;
    localparam int COUNT_W        = 5;

    // output item layout, lowest bit first
    localparam int OUT_REMOVED_LSB = 0;
    localparam int OUT_STATUS_LSB  = OUT_REMOVED_LSB + KEY_W;
    localparam int OUT_TOP_LSB     = OUT_STATUS_LSB + STATUS_W;
    localparam int OUT_VALID_LSB   = OUT_TOP_LSB + KEY_W;
    localparam int OUT_COUNT_LSB   = OUT_VALID_LSB + 1;
    localparam int OUT_FIELDS_W    = OUT_COUNT_LSB + COUNT_W;
    localparam int OUT_DATA_W      = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int IN_DATA_W       = ((KEY_W + 7) / 8) * 8;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE  = 2'd0,
        STATUS_FULL  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UP_RD,
        ST_UP_CMP,
        ST_RM_RD,
        ST_RM_LOAD,
        ST_DN_RD,
        ST_DN_CMP,
        ST_FINISH
    } state_t;

endpackage

### src/bmhq_ram.sv
module bmhq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rd_a_reg <= mem_reg[raddr_a];
        rd_b_reg <= mem_reg[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

### src/binary_min_heap_queue_unit.sv
// channel  dir  tdata                         tuser
// s_*      in   key_in[31:0]                  op (0 insert, 1 remove)
// m_*      out  removed_key, status, top_key, -
//               top_valid, entry_count
//
// m_tvalid and s_tready rise together when an item is done. An insert climbs
// one heap level per read and compare step and writes the key where it stops;
// a remove reads the root and the last entry, then descends one level per read
// and compare step. A full insert or an empty remove goes straight to finish.
// Only one item is in work at a time, set by the single compare/write loop around the heap RAM.
// The finish state holds while the previous output item is still unread.
// rst_n clears the count and the handshake; RAM contents are not cleared.
// A waiting output item does not block the next input item.
module binary_min_heap_queue_unit
    import bmhq_pkg::*;
#(
    parameter int HEAP_DEPTH = HEAP_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,  // key_in[31:0]
    input  logic                  s_tuser,  // op
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata   // removed_key, status, top_key, top_valid,
                                            // entry_count
);

    localparam int IDX_W = $clog2(HEAP_DEPTH);
    localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
    localparam int CH_W  = CNT_W + 1;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [KEY_W-1:0] root_reg, root_next;
    logic signed [KEY_W-1:0] removed_reg, removed_next;
    status_t                 status_reg, status_next;

    logic                    out_valid_reg, out_valid_next;
    logic [KEY_W-1:0]        out_removed_reg, out_removed_next;
    status_t                 out_status_reg, out_status_next;
    logic [KEY_W-1:0]        out_top_reg, out_top_next;
    logic                    out_top_valid_reg, out_top_valid_next;
    logic [COUNT_W-1:0]      out_count_reg, out_count_next;

    logic                    ram_we;
    logic [IDX_W-1:0]        ram_waddr;
    logic signed [KEY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]        ram_raddr_a;
    logic [IDX_W-1:0]        ram_raddr_b;
    logic signed [KEY_W-1:0] ram_rdata_a;
    logic signed [KEY_W-1:0] ram_rdata_b;

    logic                    accept;
    logic                    full;
    logic                    out_free;
    logic [IDX_W-1:0]        parent_idx;
    logic [CH_W-1:0]         l_idx;
    logic [CH_W-1:0]         r_idx;
    logic                    has_l;
    logic                    has_r;
    logic                    pick_r;
    logic signed [KEY_W-1:0] pick_val;
    logic [IDX_W-1:0]        pick_idx;
    logic                    up_swap;
    logic                    dn_swap;

    bmhq_ram #(
        .WIDTH (KEY_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept     = s_tvalid && s_tready;
    assign full       = (count_reg == CNT_W'(HEAP_DEPTH));
    assign out_free   = !out_valid_reg || m_tready;
    assign parent_idx = (pos_reg - IDX_W'(1)) >> 1;
    assign l_idx      = (CH_W'(pos_reg) << 1) + CH_W'(1);
    assign r_idx      = l_idx + CH_W'(1);
    assign has_l      = (l_idx < CH_W'(count_reg));
    assign has_r      = (r_idx < CH_W'(count_reg));
    assign pick_r     = has_r && (ram_rdata_b < ram_rdata_a);
    assign pick_val   = pick_r ? ram_rdata_b : ram_rdata_a;
    assign pick_idx   = pick_r ? r_idx[IDX_W-1:0] : l_idx[IDX_W-1:0];
    assign up_swap    = (ram_rdata_a > key_reg);
    assign dn_swap    = (key_reg > pick_val);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == OP_INSERT)
                    begin
                        state_next = full ? ST_FINISH : ST_UP_RD;
                    end
                    else
                    begin
                        state_next = (count_reg == '0) ? ST_FINISH : ST_RM_RD;
                    end
                end
            end
            ST_UP_RD:   state_next = (pos_reg == '0) ? ST_FINISH : ST_UP_CMP;
            ST_UP_CMP:  state_next = up_swap ? ST_UP_RD : ST_FINISH;
            ST_RM_RD:   state_next = ST_RM_LOAD;
            ST_RM_LOAD: state_next = ST_DN_RD;
            ST_DN_RD:   state_next = has_l ? ST_DN_CMP : ST_FINISH;
            ST_DN_CMP:  state_next = dn_swap ? ST_DN_RD : ST_FINISH;
            ST_FINISH:  state_next = out_free ? ST_IDLE : ST_FINISH;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        count_next   = count_reg;
        pos_next     = pos_reg;
        key_next     = key_reg;
        removed_next = removed_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = key_reg;
        ram_raddr_a  = parent_idx;
        ram_raddr_b  = pick_idx;

        out_valid_next     = out_valid_reg && !m_tready;
        out_removed_next   = out_removed_reg;
        out_status_next    = out_status_reg;
        out_top_next       = out_top_reg;
        out_top_valid_next = out_top_valid_reg;
        out_count_next     = out_count_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    removed_next = '0;
                    status_next  = STATUS_DONE;
                    if (s_tuser == OP_INSERT)
                    begin
                        if (full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            key_next   = $signed(s_tdata[KEY_W-1:0]);
                            pos_next   = count_reg[IDX_W-1:0];
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        status_next = STATUS_EMPTY;
                    end
                end
            end
            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_UP_CMP:
            begin
                ram_we = 1'b1;
                if (up_swap)
                begin
                    ram_wdata = ram_rdata_a;
                    pos_next  = parent_idx;
                end
            end
            ST_RM_RD:
            begin
                ram_raddr_a = '0;
                ram_raddr_b = IDX_W'(count_reg - CNT_W'(1));
            end
            ST_RM_LOAD:
            begin
                removed_next = ram_rdata_a;
                key_next     = ram_rdata_b;
                count_next   = count_reg - CNT_W'(1);
                pos_next     = '0;
            end
            ST_DN_RD:
            begin
                ram_raddr_a = l_idx[IDX_W-1:0];
                ram_raddr_b = r_idx[IDX_W-1:0];
                if (!has_l)
                begin
                    ram_we = 1'b1;
                end
            end
            ST_DN_CMP:
            begin
                ram_we = 1'b1;
                if (dn_swap)
                begin
                    ram_wdata = pick_val;
                    pos_next  = pick_idx;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_removed_next   = removed_reg;
                    out_status_next    = status_reg;
                    out_top_next       = (count_reg != '0) ? root_reg : '0;
                    out_top_valid_next = (count_reg != '0);
                    out_count_next     = COUNT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase

        root_next = (ram_we && (ram_waddr == '0)) ? ram_wdata : root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg           <= pos_next;
        key_reg           <= key_next;
        root_reg          <= root_next;
        removed_reg       <= removed_next;
        status_reg        <= status_next;
        out_removed_reg   <= out_removed_next;
        out_status_reg    <= out_status_next;
        out_top_reg       <= out_top_next;
        out_top_valid_reg <= out_top_valid_next;
        out_count_reg     <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata = '0;
        m_tdata[OUT_REMOVED_LSB +: KEY_W]  = out_removed_reg;
        m_tdata[OUT_STATUS_LSB +: STATUS_W] = out_status_reg;
        m_tdata[OUT_TOP_LSB +: KEY_W]      = out_top_reg;
        m_tdata[OUT_VALID_LSB]             = out_top_valid_reg;
        m_tdata[OUT_COUNT_LSB +: COUNT_W]  = out_count_reg;
    end

endmodule

### src/bmhq_checker.sv
module bmhq_checker
    import bmhq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic [KEY_W-1:0]    removed;
    logic                top_valid;

    assign st        = m_tdata[OUT_STATUS_LSB +: STATUS_W];
    assign removed   = m_tdata[OUT_REMOVED_LSB +: KEY_W];
    assign top_valid = m_tdata[OUT_VALID_LSB];

    // one item in flight: busy straight after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted back to back");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item dropped or changed while stalled");

    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == STATUS_EMPTY) |-> !top_valid && (removed == '0))
        else $error("empty remove reports a key");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st == STATUS_FULL) |-> top_valid && (removed == '0))
        else $error("full insert reports empty heap");

endmodule

bind binary_min_heap_queue_unit bmhq_checker u_bmhq_checker (.*);
